>>> src/tcfc_pkg.sv
// shared constants for the timecode / frame count converter
// no dependencies; imported by timecode_frame_count_converter_unit
package tcfc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 36;
  localparam int unsigned HOURS_WIDTH_DEF = 16;

  localparam logic [5:0]  FPS_RESET     = 6'd30;
  localparam int unsigned DROP_PER_MIN  = 2;
  localparam int unsigned DROP_PER_TEN  = 18;
  localparam int unsigned DROP_PER_HOUR = 108;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam logic [5:0]  SIXTY         = 6'd60;
  localparam logic [14:0] HOURS_MAX     = 15'h7fff;

  // command codes carried in tuser
  localparam logic CMD_TC_TO_COUNT = 1'b0;
  localparam logic CMD_COUNT_TO_TC = 1'b1;

endpackage

>>> src/tcfc_div.sv
// pipelined restoring divider, one quotient bit per register stage
// standalone; instantiated several times by timecode_frame_count_converter_unit
module tcfc_div #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 6,
  parameter int unsigned PAY_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [PAY_W-1:0] pay_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [PAY_W-1:0] pay_o
);

  logic             vld_q [NUM_W];
  logic [NUM_W-1:0] acc_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [PAY_W-1:0] pay_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] a_in;
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [PAY_W-1:0] p_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign a_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign v_in = vld_q[s-1];
      assign a_in = acc_q[s-1];
      assign r_in = rem_q[s-1];
      assign d_in = den_q[s-1];
      assign p_in = pay_q[s-1];
    end

    // shift in the next numerator bit and try a subtract
    assign trial = {r_in, a_in[NUM_W-1]};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= {a_in[NUM_W-2:0], ge};
        rem_q[s] <= ge ? DEN_W'(trial - {1'b0, d_in}) : DEN_W'(trial);
        den_q[s] <= d_in;
        pay_q[s] <= p_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = acc_q[NUM_W-1];
  assign rem_o   = rem_q[NUM_W-1];
  assign pay_o   = pay_q[NUM_W-1];

endmodule

>>> src/timecode_frame_count_converter_unit.sv
// timecode <-> signed frame count converter, top level
// depends on tcfc_pkg and tcfc_div
// (data runs through the ten-minute, dropped-minute, hour, minute and second dividers in turn)
// throughput: one beat per cycle; the whole pipeline holds while the output beat waits
// rst_ni clears every valid bit and loads frames_per_second with 30
module timecode_frame_count_converter_unit
  import tcfc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned HOURS_WIDTH = HOURS_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration: frames_per_second
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  // input beats
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // in_hours, in_minutes, in_seconds, in_frames, drop_mode, in_count (lowest bit up)
  input  logic [((HOURS_WIDTH+20+COUNT_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  logic s_axis_tuser_i,
  // result beats
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // out_count, out_hours, out_minutes, out_seconds, out_frames, out_drop,
  // is_negative, range_error (lowest bit up)
  output logic [((COUNT_WIDTH+37+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned HW  = HOURS_WIDTH;
  localparam int unsigned NW  = CW + 1;          // magnitude after drop renumbering
  localparam int unsigned PW  = HW + 13;         // 3600h + 60m + s
  localparam int unsigned AW  = HW + 9;          // drop adjustment
  localparam int unsigned TW  = HW + 21;         // fps * p + f
  localparam int unsigned BW  = CW + 3;          // cmd, drop, neg, count
  localparam int unsigned OW  = ((CW + 37 + 7) / 8) * 8;

  // ---------------------------------------------------------------------------
  // configuration register and derived divisors
  // ---------------------------------------------------------------------------
  logic [5:0]  fps_q;
  logic [5:0]  fps_eff;
  logic [15:0] per_ten_q;
  logic [11:0] per_min_q;
  logic [17:0] per_hour_q;
  logic [11:0] per_sixty_q;

  assign cfg_ready_o = 1'b1;
  assign fps_eff     = (fps_q == 6'd0) ? 6'd1 : fps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q <= FPS_RESET;
    end else if (cfg_valid_i) begin
      fps_q <= cfg_data_i;
    end
  end

  // frames per ten minutes and per dropped minute in drop-frame mode,
  // frames per hour and per full minute for the timecode split
  always_ff @(posedge clk_i) begin
    per_ten_q   <= 16'(16'd600 * 16'(fps_eff) - 16'(DROP_PER_TEN));
    per_min_q   <= 12'(12'd60 * 12'(fps_eff) - 12'(DROP_PER_MIN));
    per_hour_q  <= 18'(18'(SECS_PER_HOUR) * 18'(fps_eff));
    per_sixty_q <= 12'(12'(SIXTY) * 12'(fps_eff));
  end

  // global hold: every stage advances only when the output beat can move
  logic en;
  logic out_valid_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // ---------------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------------
  logic                 v1_q, cmd1_q, drop1_q;
  logic signed [HW-1:0] h1_q;
  logic [5:0]           m1_q, s1_q;
  logic [6:0]           f1_q;
  logic signed [CW-1:0] c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= s_axis_tuser_i;
      h1_q    <= s_axis_tdata_i[HW-1:0];
      m1_q    <= s_axis_tdata_i[HW+5:HW];
      s1_q    <= s_axis_tdata_i[HW+11:HW+6];
      f1_q    <= s_axis_tdata_i[HW+18:HW+12];
      drop1_q <= s_axis_tdata_i[HW+19];
      c1_q    <= s_axis_tdata_i[HW+20+CW-1:HW+20];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: seconds total, drop adjustment, count magnitude
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] hx;
  logic signed [PW-1:0] p_d;
  logic [13:0]          m205;
  logic [2:0]           tens_m;
  logic signed [AW-1:0] dadj_d;
  logic [CW-1:0]        n_d;

  assign hx     = PW'(h1_q);
  assign p_d    = hx * $signed(PW'(SECS_PER_HOUR))
                + $signed(PW'(m1_q) * PW'(60)) + $signed(PW'(s1_q));
  // floor(m/10) for six-bit minutes by reciprocal multiply
  assign m205   = 14'(m1_q) * 14'd205;
  assign tens_m = 3'(m205 >> 11);
  // dropped numbers: 108 per hour plus two per minute not a multiple of ten;
  // 60h is a multiple of ten, so floor of tens of minutes splits exactly
  assign dadj_d = AW'(h1_q) * $signed(AW'(DROP_PER_HOUR))
                + $signed(AW'({(7'(m1_q) - 7'(tens_m)), 1'b0}));
  assign n_d    = c1_q[CW-1] ? CW'(-c1_q) : CW'(c1_q);

  logic                 v2_q, cmd2_q, drop2_q, neg2_q;
  logic signed [PW-1:0] p2_q;
  logic signed [AW-1:0] dadj2_q;
  logic [6:0]           f2_q;
  logic [CW-1:0]        n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd2_q  <= cmd1_q;
      drop2_q <= drop1_q;
      neg2_q  <= c1_q[CW-1];
      p2_q    <= p_d;
      dadj2_q <= dadj_d;
      f2_q    <= f1_q;
      n2_q    <= n_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: rate multiply
  // ---------------------------------------------------------------------------
  logic                 v3_q, cmd3_q, drop3_q, neg3_q;
  logic signed [TW-1:0] prod3_q;
  logic signed [AW-1:0] dadj3_q;
  logic [6:0]           f3_q;
  logic [CW-1:0]        n3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd3_q  <= cmd2_q;
      drop3_q <= drop2_q;
      neg3_q  <= neg2_q;
      prod3_q <= TW'(p2_q) * TW'($signed({1'b0, fps_eff}));
      dadj3_q <= dadj2_q;
      f3_q    <= f2_q;
      n3_q    <= n2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: count total, wrapped to the count width
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] total_d;
  logic signed [TW-1:0] tot_sub;

  assign tot_sub = drop3_q ? TW'(dadj3_q) : '0;
  assign total_d = prod3_q + $signed(TW'(f3_q)) - tot_sub;

  logic            v4_q, cmd4_q, drop4_q, neg4_q;
  logic [CW-1:0]   cnt4_q;
  logic [CW-1:0]   n4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd4_q  <= cmd3_q;
      drop4_q <= drop3_q;
      neg4_q  <= neg3_q;
      cnt4_q  <= CW'(total_d);
      n4_q    <= n3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // divider 1: magnitude over frames per ten minutes
  // ---------------------------------------------------------------------------
  logic [BW-1:0]    base4;
  logic             d1_v;
  logic [CW-1:0]    d1_q;
  logic [15:0]      d1_r;
  logic [BW+CW-1:0] d1_p;

  assign base4 = {cmd4_q, drop4_q, neg4_q, cnt4_q};

  tcfc_div #(.NUM_W(CW), .DEN_W(16), .PAY_W(BW + CW)) u_div_ten (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v4_q), .num_i(n4_q), .den_i(per_ten_q), .pay_i({base4, n4_q}),
    .valid_o(d1_v), .quot_o(d1_q), .rem_o(d1_r), .pay_o(d1_p)
  );

  // stage 5: add back 18 numbers per ten minutes, set up the per-minute divide
  logic          v5_q;
  logic [BW-1:0] base5_q;
  logic [NW-1:0] adj5_q;
  logic [15:0]   remm5_q;
  logic [CW-1:0] n5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base5_q <= d1_p[BW+CW-1:CW];
      n5_q    <= d1_p[CW-1:0];
      adj5_q  <= NW'(d1_p[CW-1:0]) + NW'(NW'(d1_q) * NW'(DROP_PER_TEN));
      // remainders of two or less fall in the frames of a full minute
      remm5_q <= (d1_r > 16'(DROP_PER_MIN)) ? 16'(d1_r - 16'(DROP_PER_MIN)) : 16'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // divider 2: remainder over frames per dropped minute
  // ---------------------------------------------------------------------------
  logic                  d2_v;
  logic [15:0]           d2_q;
  logic [11:0]           d2_r;
  logic [BW+NW+CW-1:0]   d2_p;

  tcfc_div #(.NUM_W(16), .DEN_W(12), .PAY_W(BW + NW + CW)) u_div_min (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v5_q), .num_i(remm5_q), .den_i(per_min_q),
    .pay_i({base5_q, adj5_q, n5_q}),
    .valid_o(d2_v), .quot_o(d2_q), .rem_o(d2_r), .pay_o(d2_p)
  );

  // stage 6: renumbered magnitude
  logic          v6_q;
  logic [BW-1:0] base6_q;
  logic [NW-1:0] nn6_q;
  logic          drop_d2;

  assign drop_d2 = d2_p[BW+NW+CW-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base6_q <= d2_p[BW+NW+CW-1:NW+CW];
      nn6_q   <= drop_d2 ? NW'(d2_p[NW+CW-1:CW] + NW'({d2_q, 1'b0}))
                         : NW'(d2_p[CW-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // divider 3: hours over frames per hour; divider 4: minutes over frames per
  // minute; divider 5: seconds and frames over the rate
  // ---------------------------------------------------------------------------
  logic          d3_v;
  logic [NW-1:0] d3_q;
  logic [17:0]   d3_r;
  logic [BW-1:0] d3_p;

  tcfc_div #(.NUM_W(NW), .DEN_W(18), .PAY_W(BW)) u_div_hour (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v6_q), .num_i(nn6_q), .den_i(per_hour_q), .pay_i(base6_q),
    .valid_o(d3_v), .quot_o(d3_q), .rem_o(d3_r), .pay_o(d3_p)
  );

  logic             d4_v;
  logic [17:0]      d4_q;
  logic [11:0]      d4_r;
  logic [BW+NW-1:0] d4_p;

  tcfc_div #(.NUM_W(18), .DEN_W(12), .PAY_W(BW + NW)) u_div_min60 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d3_v), .num_i(d3_r), .den_i(per_sixty_q), .pay_i({d3_p, d3_q}),
    .valid_o(d4_v), .quot_o(d4_q), .rem_o(d4_r), .pay_o(d4_p)
  );

  // minutes stay below sixty, so six bits carry them on
  logic             d5_v;
  logic [11:0]      d5_q;
  logic [5:0]       d5_r;
  logic [BW+NW+5:0] d5_p;

  tcfc_div #(.NUM_W(12), .DEN_W(6), .PAY_W(BW + NW + 6)) u_div_sec (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d4_v), .num_i(d4_r), .den_i(fps_eff), .pay_i({d4_p, d4_q[5:0]}),
    .valid_o(d5_v), .quot_o(d5_q), .rem_o(d5_r), .pay_o(d5_p)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic          o_cmd, o_drop, o_neg, o_sat;
  logic [CW-1:0] o_cnt;
  logic [NW-1:0] o_hrs;
  logic [5:0]    o_min, o_sec;

  assign o_cmd  = d5_p[BW+NW+5];
  assign o_drop = d5_p[BW+NW+4];
  assign o_neg  = d5_p[BW+NW+3];
  assign o_cnt  = d5_p[BW+NW+2:NW+6];
  assign o_hrs  = d5_p[NW+5:6];
  assign o_min  = d5_p[5:0];
  assign o_sec  = d5_q[5:0];
  assign o_sat  = (o_hrs > NW'(HOURS_MAX));

  logic          out_cmd_q;
  logic [CW-1:0] out_count_q;
  logic [14:0]   out_hours_q;
  logic [5:0]    out_minutes_q, out_seconds_q;
  logic [6:0]    out_frames_q;
  logic          out_drop_q, is_negative_q, range_error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d5_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cmd_q <= o_cmd;
      if (o_cmd == CMD_COUNT_TO_TC) begin
        out_count_q   <= '0;
        out_hours_q   <= o_sat ? HOURS_MAX : 15'(o_hrs);
        out_minutes_q <= o_min;
        out_seconds_q <= o_sec;
        out_frames_q  <= 7'(d5_r);
        out_drop_q    <= o_drop;
        is_negative_q <= o_neg;
        range_error_q <= o_sat;
      end else begin
        out_count_q   <= o_cnt;
        out_hours_q   <= '0;
        out_minutes_q <= '0;
        out_seconds_q <= '0;
        out_frames_q  <= '0;
        out_drop_q    <= 1'b0;
        is_negative_q <= 1'b0;
        range_error_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OW'({range_error_q, is_negative_q, out_drop_q, out_frames_q,
                                out_seconds_q, out_minutes_q, out_hours_q, out_count_q});

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_sat_hours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && range_error_q) |-> (out_hours_q == HOURS_MAX))
    else $error("range error without saturated hours");

  a_tc_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cmd_q == CMD_COUNT_TO_TC) |->
      (out_count_q == '0 && out_minutes_q < SIXTY && out_seconds_q < SIXTY))
    else $error("timecode result out of range");

  a_cnt_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cmd_q == CMD_TC_TO_COUNT) |->
      (out_hours_q == '0 && out_frames_q == '0 && !range_error_q && !is_negative_q))
    else $error("count result carries timecode fields");

endmodule
